>>> design/fdl_pkg.sv
package fdl_pkg;

  localparam int DEPTH_DEF       = 4096;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int          DELAY_BITS  = 20;
  localparam logic [19:0] DELAY_RESET = 20'd256;

  // entries held between front and back
  localparam int QUEUE_DEPTH = 2;
  // back end: read stage, multiply stage, output register
  localparam int BACK_STAGES = 3;

endpackage

>>> design/fractional_delay_line_linear_interp.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    in_tdata: sample_in
// out_      out  out_tvalid/out_tready  out_tdata: sample_out
// cfg_      in   cfg_wr_en              cfg_wr_data: delay_samples
//
// One item per cycle sustained while out_ is not stalled; an accepted item passes
// the queue write at accept, then store read, multiply and output register.
// Store needs no clearing pass: a write pointer plus a wrapped flag mark
// entries never written, which read as zero. Ready right after reset.
// A stall on out_ freezes the back end; the two-entry queue keeps in_tready
// up until it fills. DEPTH must be a power of two.
module fractional_delay_line_linear_interp #(
  parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,    // [SB-1:0] sample_in
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,   // [SB-1:0] sample_out
  input  logic                                cfg_wr_en,
  input  logic [fdl_pkg::DELAY_BITS-1:0]      cfg_wr_data  // delay_samples
);
  import fdl_pkg::*;

  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int ENTRY_W   = SAMPLE_BITS + 2 * ADDR_BITS + FRAC_BITS + 2;
  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [DELAY_BITS-1:0]  delay_r;
  logic                   push, q_room, q_has, q_pop;
  logic [ENTRY_W-1:0]     f_entry, q_entry;
  logic [SAMPLE_BITS-1:0] res_sample;

  always_ff @(posedge clk) begin
    if (!rst_n)         delay_r <= DELAY_RESET;
    else if (cfg_wr_en) delay_r <= cfg_wr_data;
  end

  assign in_tready = q_room;
  assign push      = in_tvalid && q_room;

  fdl_front #(
    .DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS),
    .ADDR_BITS(ADDR_BITS), .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .accept(push),
    .sample(in_tdata[SAMPLE_BITS-1:0]), .delay(delay_r), .entry(f_entry)
  );

  fdl_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(f_entry), .has_room(q_room),
    .pop(q_pop), .has_data(q_has), .pop_data(q_entry)
  );

  fdl_back #(
    .DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS),
    .ADDR_BITS(ADDR_BITS), .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_has_data(q_has), .q_data(q_entry), .q_pop(q_pop),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_sample(res_sample)
  );

  assign out_tdata = TDATA_W'(res_sample);

endmodule

>>> design/fdl_front.sv
module fdl_front #(
  parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_BITS   = $clog2(DEPTH),
  parameter int ENTRY_W     = SAMPLE_BITS + 2 * ADDR_BITS + FRAC_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [fdl_pkg::DELAY_BITS-1:0]   delay,
  output logic [ENTRY_W-1:0]               entry
);
  import fdl_pkg::*;

  localparam int PW = ADDR_BITS + FRAC_BITS;

  logic [ADDR_BITS-1:0] wp_r, wp_nxt;
  logic                 full_r, full_nxt;
  logic [PW-1:0]        point;
  logic [ADDR_BITS-1:0] lo_idx, hi_idx;
  logic [FRAC_BITS-1:0] frac;
  logic                 lo_ok, hi_ok;

  // read point is modulo DEPTH samples, so plain PW-bit wrap-around
  assign point  = {wp_r, FRAC_BITS'(0)} - PW'(delay);
  assign lo_idx = point[PW-1:FRAC_BITS];
  assign frac   = point[FRAC_BITS-1:0];
  assign hi_idx = ADDR_BITS'(lo_idx + 1'b1);

  // writes go in address order, so an entry holds data once wp has passed it
  assign lo_ok = full_r || (lo_idx <= wp_r);
  assign hi_ok = full_r || (hi_idx <= wp_r);

  assign entry = {hi_ok, lo_ok, frac, lo_idx, wp_r, sample};

  always_comb begin
    wp_nxt   = wp_r;
    full_nxt = full_r;
    if (accept) begin
      wp_nxt = ADDR_BITS'(wp_r + 1'b1);
      if (wp_r == ADDR_BITS'(DEPTH - 1)) full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      full_r <= full_nxt;
    end
  end

endmodule

>>> design/fdl_queue.sv
module fdl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             has_room,
  input  logic             pop,
  output logic             has_data,
  output logic [WIDTH-1:0] pop_data
);
  import fdl_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  assign has_room = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign has_data = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : PTR_BITS'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : PTR_BITS'(rd_ptr_r + 1'b1);
    end
    if (push && !pop)      count_nxt = CNT_BITS'(count_r + 1'b1);
    else if (pop && !push) count_nxt = CNT_BITS'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> design/fdl_back.sv
module fdl_back #(
  parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_BITS   = $clog2(DEPTH),
  parameter int ENTRY_W     = SAMPLE_BITS + 2 * ADDR_BITS + FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_has_data,
  input  logic [ENTRY_W-1:0]     q_data,
  output logic                   q_pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [SAMPLE_BITS-1:0] res_sample
);
  import fdl_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int AB  = ADDR_BITS;
  localparam int PW2 = SB + FB + 2;
  localparam int HALF = 1 << (FB - 1);

  localparam int O_WP   = SB;
  localparam int O_LO   = SB + AB;
  localparam int O_FRAC = SB + 2 * AB;
  localparam int O_LOK  = SB + 2 * AB + FB;
  localparam int O_HOK  = O_LOK + 1;

  typedef enum logic [1:0] {SRC_MEM, SRC_FWD, SRC_ZERO} src_t;

  logic [SB-1:0] e_sample;
  logic [AB-1:0] e_wp, e_lo, e_hi;
  logic [FB-1:0] e_frac;
  logic          e_lo_ok, e_hi_ok;
  logic          adv;
  src_t          lo_src, hi_src;

  assign e_sample = q_data[SB-1:0];
  assign e_wp     = q_data[O_LO-1:O_WP];
  assign e_lo     = q_data[O_FRAC-1:O_LO];
  assign e_frac   = q_data[O_LOK-1:O_FRAC];
  assign e_lo_ok  = q_data[O_LOK];
  assign e_hi_ok  = q_data[O_HOK];
  assign e_hi     = AB'(e_lo + 1'b1);

  assign adv   = !res_valid || res_ready;
  assign q_pop = q_has_data && adv;

  // two copies of the store, one read port each; same item's write is forwarded
  logic [SB-1:0] mem_a_r [DEPTH];
  logic [SB-1:0] mem_b_r [DEPTH];
  logic [SB-1:0] rd_lo_r, rd_hi_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_a_r[e_wp] <= e_sample;
      rd_lo_r       <= mem_a_r[e_lo];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_b_r[e_wp] <= e_sample;
      rd_hi_r       <= mem_b_r[e_hi];
    end
  end

  always_comb begin
    if (e_lo == e_wp)  lo_src = SRC_FWD;
    else if (!e_lo_ok) lo_src = SRC_ZERO;
    else               lo_src = SRC_MEM;
    if (e_hi == e_wp)  hi_src = SRC_FWD;
    else if (!e_hi_ok) hi_src = SRC_ZERO;
    else               hi_src = SRC_MEM;
  end

  // stage 1: read data
  logic          s1_valid_r;
  src_t          s1_lo_src_r, s1_hi_src_r;
  logic [SB-1:0] s1_sample_r;
  logic [FB-1:0] s1_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_lo_src_r <= lo_src;
      s1_hi_src_r <= hi_src;
      s1_sample_r <= e_sample;
      s1_frac_r   <= e_frac;
    end
  end

  // stage 2: select lo and hi, register lo and (hi - lo) * frac
  logic signed [SB-1:0]  lo_s, hi_s;
  logic signed [SB:0]    diff;
  logic signed [FB:0]    frac_s;
  logic signed [PW2-1:0] prod;
  logic                  s2_valid_r;
  logic signed [SB-1:0]  s2_lo_r;
  logic signed [PW2-1:0] s2_prod_r;

  always_comb begin
    case (s1_lo_src_r)
      SRC_FWD:  lo_s = s1_sample_r;
      SRC_ZERO: lo_s = '0;
      default:  lo_s = rd_lo_r;
    endcase
    case (s1_hi_src_r)
      SRC_FWD:  hi_s = s1_sample_r;
      SRC_ZERO: hi_s = '0;
      default:  hi_s = rd_hi_r;
    endcase
  end

  assign diff   = {hi_s[SB-1], hi_s} - {lo_s[SB-1], lo_s};
  assign frac_s = {1'b0, s1_frac_r};
  assign prod   = PW2'(diff) * PW2'(frac_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_lo_r   <= lo_s;
      s2_prod_r <= prod;
    end
  end

  // stage 3: round, floor shift, add base
  logic signed [PW2-1:0] rnd, shifted, sum;
  logic                  res_valid_r;
  logic [SB-1:0]         res_sample_r;

  assign rnd     = s2_prod_r + PW2'(HALF);
  assign shifted = rnd >>> FB;
  assign sum     = PW2'(s2_lo_r) + shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_sample_r <= sum[SB-1:0];
  end

  assign res_valid  = res_valid_r;
  assign res_sample = res_sample_r;

endmodule

>>> design/fdl_checker.sv
module fdl_checker #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);
  import fdl_pkg::*;

  localparam int CAP = QUEUE_DEPTH + BACK_STAGES;

  logic [3:0] pending_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= '0;
    else if (in_acc && !out_acc) pending_r <= pending_r + 4'd1;
    else if (out_acc && !in_acc) pending_r <= pending_r - 4'd1;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not ready out of reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 4'd0 || in_acc)
    else $error("result without item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'(CAP))
    else $error("more items in flight than storage");

endmodule

bind fractional_delay_line_linear_interp fdl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fdl_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

>>> dv/fractional_delay_line_linear_interp_tb.sv
module fractional_delay_line_linear_interp_tb;
  import fdl_pkg::*;

  localparam int SB        = SAMPLE_BITS_DEF;
  localparam int TDW       = ((SB + 7) / 8) * 8;
  localparam int STORE_LEN = DEPTH_DEF;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS_DEF;
  localparam longint SPAN     = longint'(STORE_LEN) * FRAC_ONE;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + BACK_STAGES + 4;
  localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDW-1:0]        in_tdata;   // [SB-1:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDW-1:0]        out_tdata;  // [SB-1:0] sample_out
  logic                  cfg_wr_en;
  logic [DELAY_BITS-1:0] cfg_wr_data;

  fractional_delay_line_linear_interp u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic signed [SB-1:0]  tap_store [STORE_LEN];
  int unsigned           write_pos;
  logic [DELAY_BITS-1:0] delay_q;

  logic [SB-1:0] expected_out [$];
  logic [SB-1:0] want;
  int            errors;
  bit            in_no_idle;
  bit            out_no_idle;
  int            out_hold_len;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [SB-1:0] delayed_sample(input logic [SB-1:0] s);
    longint point, frac, lo_idx, hi_idx, lo, hi, acc, res;
    tap_store[write_pos] = s;
    point  = (longint'(write_pos) * FRAC_ONE + SPAN - longint'(delay_q) % SPAN) % SPAN;
    frac   = point % FRAC_ONE;
    lo_idx = point / FRAC_ONE;
    hi_idx = (lo_idx + 1) % STORE_LEN;
    lo     = longint'(tap_store[lo_idx]);
    hi     = longint'(tap_store[hi_idx]);
    acc    = lo * (FRAC_ONE - frac) + hi * frac + FRAC_ONE / 2;
    res    = acc >>> FRAC_BITS_DEF;
    write_pos = (write_pos + 1) % STORE_LEN;
    return res[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SB'($urandom_range(0, 2)) - SB'(1);
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic drive_sample(input logic [SB-1:0] s);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDW'(s);
    do @(posedge clk); while (!in_tready);
    expected_out.push_back(delayed_sample(s));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_outputs();
    idle_input();
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // block must be idle
  task automatic load_delay(input logic [DELAY_BITS-1:0] d);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    delay_q = d;
  endtask

  task automatic test_default_delay();
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample('0);
    drive_sample('1);
    drive_sample(SB'(1));
    drive_sample({(SB/2){2'b01}});
    drive_sample({(SB/2){2'b10}});
    drain_outputs();
  endtask

  // output follows the current input
  task automatic test_zero_delay();
    load_delay('0);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample(pick_sample());
    drain_outputs();
  endtask

  // read point between the item just written and the one before
  task automatic test_sub_sample_delay();
    load_delay(DELAY_BITS'(FRAC_ONE / 2));
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drain_outputs();
    load_delay(DELAY_BITS'(1));
    drive_sample(SAMPLE_MIN);
    drive_sample(SAMPLE_MAX);
    drain_outputs();
  endtask

  task automatic test_longest_delay();
    load_delay(DELAY_MAX);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample(pick_sample());
    drain_outputs();
  endtask

  // lower neighbour at the top of the store, upper one wraps to entry zero
  task automatic test_store_wrap_neighbour();
    load_delay(DELAY_BITS'(longint'(write_pos) * FRAC_ONE + FRAC_ONE / 2));
    drive_sample(pick_sample());
    drive_sample(pick_sample());
    drain_outputs();
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_output_backpressure();
    load_delay(DELAY_BITS'(3 * FRAC_ONE + 77));
    in_no_idle   = 1'b1;
    out_hold_len = 40;
    repeat (40) drive_sample(pick_sample());
    in_no_idle = 1'b0;
    drain_outputs();
  endtask

  task automatic test_random_delays();
    logic [DELAY_BITS-1:0] d;
    for (int p = 0; p < 8; p++) begin
      case (p % 5)
        0: d = DELAY_BITS'(longint'($urandom_range(1, write_pos)) * FRAC_ONE);
        1: d = DELAY_BITS'($urandom_range(0, write_pos * FRAC_ONE));
        2: d = DELAY_BITS'($urandom);
        3: d = DELAY_BITS'($urandom_range(0, FRAC_ONE - 1));
        default: d = DELAY_BITS'($urandom_range(FRAC_ONE, 64 * FRAC_ONE));
      endcase
      load_delay(d);
      in_no_idle  = (p % 3 == 2);
      out_no_idle = (p % 3 == 2);
      repeat (190) drive_sample(pick_sample());
      drain_outputs();
    end
    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
  endtask

  // result sink
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = out_no_idle ? 0 : $urandom_range(0, 4);
      if (out_hold_len > 0) begin
        gap = out_hold_len;
        out_hold_len = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata[SB-1:0]);
      end else begin
        want = expected_out.pop_front();
        if (out_tdata[SB-1:0] !== want) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, want, out_tdata[SB-1:0]);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    errors       = 0;
    in_no_idle   = 1'b0;
    out_no_idle  = 1'b0;
    out_hold_len = 0;
    write_pos    = 0;
    delay_q      = DELAY_RESET;
    foreach (tap_store[i]) tap_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_delay();
    test_zero_delay();
    test_sub_sample_delay();
    test_longest_delay();
    test_store_wrap_neighbour();
    test_output_backpressure();
    test_random_delays();

    drain_outputs();
    if (errors == 0 && expected_out.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/fdl_pkg.sv
design/fdl_front.sv
design/fdl_queue.sv
design/fdl_back.sv
design/fractional_delay_line_linear_interp.sv
design/fdl_checker.sv
dv/fractional_delay_line_linear_interp_tb.sv
